/* rtl/sqvg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad vertex generation package
// Payload types, the per-quad record that the front end hands to the vertex
// pipeline, and the fixed constants of the sine polynomial.
// ----------------------------------------------------------------------------
package sqvg_pkg;

	typedef struct packed {
		logic [31:0] src_xy;
		logic [31:0] src_size;
		logic [31:0] dst_xy;
		logic [31:0] dst_size;
		logic [31:0] pivot;
		logic [31:0] tex_scale;
		logic [15:0] angle;
		logic [31:0] tint;
	} sqvg_in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
		logic [31:0]        tint_out;
		logic [1:0]         corner;
		logic               last;
	} sqvg_out_t;

	// One classified quad: centre terms divided out, sine and cosine known.
	typedef struct packed {
		logic [15:0]        sx;
		logic [15:0]        sy;
		logic [15:0]        sw;
		logic [15:0]        sh;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic [15:0]        dw;
		logic [15:0]        dh;
		logic [15:0]        su;
		logic [15:0]        sv;
		logic [31:0]        tint;
		logic [27:0]        cx;
		logic [27:0]        cy;
		logic signed [15:0] sn;
		logic signed [15:0] cs;
	} sqvg_quad_t;

	localparam logic [14:0] SIN_A = 15'd25736;
	localparam logic [14:0] SIN_B = 15'd10512;
	localparam logic [14:0] SIN_C = 15'd1160;
	localparam logic [14:0] QUARTER = 15'd16384;

	// Corner offsets in emission order, indexed by corner number.
	localparam logic [3:0] CORNER_OX = 4'b0110;
	localparam logic [3:0] CORNER_OY = 4'b1100;

endpackage

/* rtl/sqvg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad front end
// Takes a quad, divides the pivot by the source size four quotient bits per
// cycle and evaluates sine and cosine in a short multiply chain.
// ----------------------------------------------------------------------------
module sqvg_front import sqvg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sqvg_in_t   in_data,
	output logic       q_valid,
	input  logic       q_ready,
	output sqvg_quad_t q_data
);

	logic        busy_q;
	logic [2:0]  cnt_q;
	sqvg_quad_t  quad_q;
	logic [27:0] dvdx_q, dvdy_q;
	logic [15:0] remx_q, remy_q;
	logic [14:0] ts_q, tc_q;
	logic        ngs_q, ngc_q;
	logic [14:0] t2s_q, t2c_q, ins_q, inc_q, mds_q, mdc_q;
	logic signed [15:0] sn_q, cs_q;
	logic        take;
	logic [43:0] stx, sty;
	logic [15:0] ang_c;
	logic [29:0] ps, pc;

	// Four restoring division steps: returns {remainder, shifted dividend}.
	function automatic logic [43:0] div4(input logic [15:0] rem, input logic [27:0] dvd,
			input logic [15:0] dsr);
		logic [15:0] r;
		logic [27:0] d;
		logic [17:0] trial;
		r = rem;
		d = dvd;
		for (int i = 0; i < 4; i++) begin
			trial = {1'b0, r, d[27]} - {2'b00, dsr};
			if (!trial[17]) begin
				r = trial[15:0];
				d = {d[26:0], 1'b1};
			end else begin
				r = {r[14:0], d[27]};
				d = {d[26:0], 1'b0};
			end
		end
		return {r, d};
	endfunction

	function automatic logic [14:0] fold(input logic [15:0] a);
		return a[14] ? 15'(QUARTER - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
	endfunction

	assign q_valid  = busy_q && (cnt_q == 3'd7);
	assign in_ready = !busy_q || (q_valid && q_ready);
	assign take     = in_valid && in_ready;
	assign stx      = div4(remx_q, dvdx_q, quad_q.sw);
	assign sty      = div4(remy_q, dvdy_q, quad_q.sh);
	assign ang_c    = in_data.angle + 16'h4000;
	assign ps       = ts_q * mds_q;
	assign pc       = tc_q * mdc_q;

	always_comb begin
		q_data    = quad_q;
		q_data.cx = (quad_q.sw == 16'd0) ? 28'd0 : dvdx_q;
		q_data.cy = (quad_q.sh == 16'd0) ? 28'd0 : dvdy_q;
		q_data.sn = sn_q;
		q_data.cs = cs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd0;
		end else if (q_valid && q_ready) begin
			busy_q <= 1'b0;
		end else if (busy_q && cnt_q != 3'd7) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			quad_q.sx   <= in_data.src_xy[15:0];
			quad_q.sy   <= in_data.src_xy[31:16];
			quad_q.sw   <= in_data.src_size[15:0];
			quad_q.sh   <= in_data.src_size[31:16];
			quad_q.dx   <= signed'(in_data.dst_xy[15:0]);
			quad_q.dy   <= signed'(in_data.dst_xy[31:16]);
			quad_q.dw   <= in_data.dst_size[15:0];
			quad_q.dh   <= in_data.dst_size[31:16];
			quad_q.su   <= in_data.tex_scale[15:0];
			quad_q.sv   <= in_data.tex_scale[31:16];
			quad_q.tint <= in_data.tint;
			quad_q.cx   <= 28'd0;
			quad_q.cy   <= 28'd0;
			quad_q.sn   <= 16'sd0;
			quad_q.cs   <= 16'sd0;
			dvdx_q      <= {in_data.pivot[15:0], 12'd0};
			dvdy_q      <= {in_data.pivot[31:16], 12'd0};
			remx_q      <= 16'd0;
			remy_q      <= 16'd0;
			ts_q        <= fold(in_data.angle);
			tc_q        <= fold(ang_c);
			ngs_q       <= in_data.angle[15];
			ngc_q       <= ang_c[15];
		end else if (busy_q && cnt_q != 3'd7) begin
			{remx_q, dvdx_q} <= stx;
			{remy_q, dvdy_q} <= sty;
		end
		// The polynomial chain runs freely; its operands hold still after a transfer.
		t2s_q <= 15'((30'(ts_q) * 30'(ts_q)) >> 14);
		t2c_q <= 15'((30'(tc_q) * 30'(tc_q)) >> 14);
		ins_q <= SIN_B - 15'((30'(t2s_q) * 30'(SIN_C)) >> 14);
		inc_q <= SIN_B - 15'((30'(t2c_q) * 30'(SIN_C)) >> 14);
		mds_q <= SIN_A - 15'((30'(t2s_q) * 30'(ins_q)) >> 14);
		mdc_q <= SIN_A - 15'((30'(t2c_q) * 30'(inc_q)) >> 14);
		sn_q  <= ngs_q ? -signed'({1'b0, ps[28:14]}) : signed'({1'b0, ps[28:14]});
		cs_q  <= ngc_q ? -signed'({1'b0, pc[28:14]}) : signed'({1'b0, pc[28:14]});
	end

endmodule

/* rtl/sqvg_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad queue
// Two-entry queue of classified quads between the front end and the vertex
// pipeline.
// ----------------------------------------------------------------------------
module sqvg_fifo import sqvg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	output logic       wr_ready,
	input  sqvg_quad_t wr_data,
	output logic       rd_valid,
	input  logic       rd_ready,
	output sqvg_quad_t rd_data
);

	sqvg_quad_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule

/* rtl/sqvg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad vertex pipeline
// Walks the four corners of a quad, one per cycle while the output is not
// stalled, through scale, rotate and round stages into the output register.
// ----------------------------------------------------------------------------
module sqvg_back import sqvg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_ready,
	input  sqvg_quad_t q_data,
	output logic       out_valid,
	input  logic       out_ready,
	output sqvg_out_t  out_data
);

	logic       adv, issue, ox, oy;
	logic [1:0] crn_q;
	logic [16:0] ub, vb;
	logic signed [29:0] cxe, cye;

	logic               v_s1, v_s2, v_s3;
	logic signed [29:0] dcx_s1, dcy_s1;
	logic [15:0]        dw_s1, dh_s1;
	logic [32:0]        up_s1, vp_s1;
	logic signed [15:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [15:0] sn_s1, cs_s1, sn_s2, cs_s2;
	logic [31:0]        tint_s1, tint_s2, tint_s3;
	logic [1:0]         crn_s1, crn_s2, crn_s3;
	logic signed [46:0] xd_s2, yd_s2;
	logic signed [31:0] u_s2, v_s2q, u_s3, v_s3q;
	logic signed [62:0] xc_s3, ys_s3, xs_s3, yc_s3;
	logic signed [34:0] vv;
	logic signed [63:0] ax, ay, axs, ays;

	function automatic logic signed [31:0] sat(input logic signed [63:0] a);
		if (a > 64'sd2147483647) return 32'sh7fffffff;
		if (a < -64'sd2147483648) return 32'sh80000000;
		return a[31:0];
	endfunction

	assign adv     = !out_valid || out_ready;
	assign issue   = adv && q_valid;
	assign q_ready = adv && (crn_q == 2'd3);
	assign ox      = CORNER_OX[crn_q];
	assign oy      = CORNER_OY[crn_q];
	assign cxe     = signed'({2'b00, q_data.cx});
	assign cye     = signed'({2'b00, q_data.cy});
	assign ub      = {1'b0, q_data.sx} + (ox ? {1'b0, q_data.sw} : 17'd0);
	assign vb      = {1'b0, q_data.sy} + (oy ? {1'b0, q_data.sh} : 17'd0);
	assign vv      = 35'sd65536 - signed'({2'b00, vp_s1});
	assign ax      = (64'(dx_s3) <<< 30) + 64'(xc_s3) - 64'(ys_s3) + 64'sd131072;
	assign ay      = (64'(dy_s3) <<< 30) + 64'(xs_s3) + 64'(yc_s3) + 64'sd131072;
	assign axs     = ax >>> 18;
	assign ays     = ay >>> 18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crn_q     <= 2'd0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			if (issue) crn_q <= crn_q + 2'd1;
			v_s1      <= issue;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dcx_s1  <= ox ? 30'sh10000 - cxe : -cxe;
			dcy_s1  <= oy ? 30'sh10000 - cye : -cye;
			dw_s1   <= q_data.dw;
			dh_s1   <= q_data.dh;
			up_s1   <= {16'd0, ub} * {17'd0, q_data.su};
			vp_s1   <= {16'd0, vb} * {17'd0, q_data.sv};
			dx_s1   <= q_data.dx;
			dy_s1   <= q_data.dy;
			sn_s1   <= q_data.sn;
			cs_s1   <= q_data.cs;
			tint_s1 <= q_data.tint;
			crn_s1  <= crn_q;

			xd_s2   <= dcx_s1 * signed'({1'b0, dw_s1});
			yd_s2   <= dcy_s1 * signed'({1'b0, dh_s1});
			u_s2    <= (up_s1 > 33'h07fffffff) ? 32'sh7fffffff : signed'(up_s1[31:0]);
			v_s2q   <= (vv < -35'sd2147483648) ? 32'sh80000000 : vv[31:0];
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			sn_s2   <= sn_s1;
			cs_s2   <= cs_s1;
			tint_s2 <= tint_s1;
			crn_s2  <= crn_s1;

			xc_s3   <= xd_s2 * cs_s2;
			ys_s3   <= yd_s2 * sn_s2;
			xs_s3   <= xd_s2 * sn_s2;
			yc_s3   <= yd_s2 * cs_s2;
			u_s3    <= u_s2;
			v_s3q   <= v_s2q;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			tint_s3 <= tint_s2;
			crn_s3  <= crn_s2;

			out_data.pos_x    <= sat(axs);
			out_data.pos_y    <= sat(ays);
			out_data.tex_u    <= u_s3;
			out_data.tex_v    <= v_s3q;
			out_data.tint_out <= tint_s3;
			out_data.corner   <= crn_s3;
			out_data.last     <= (crn_s3 == 2'd3);
		end
	end

endmodule

/* rtl/sprite_quad_vertex_generation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad vertex generation unit
// Turns one sprite quad into its four rotated, scaled corner vertices.
// ----------------------------------------------------------------------------
// Usage: a quad is transferred on in_valid/in_ready; its four vertices leave
// on out_valid/out_ready in corner order (0,0), (1,0), (1,1), (0,1), with
// last set on the fourth. Both channels carry one packed struct.
// The front end runs the centre division, which produces four quotient bits
// per cycle, and then hands the quad off; it takes the next quad in the same
// cycle as that hand-off. The vertex pipeline then sends one vertex per cycle
// while the receiver does not stall.
// A two-entry queue sits between front end and vertex pipeline, so the front
// end keeps taking quads while the receiver stalls, until the queue fills.
// A stalled receiver freezes the whole vertex pipeline with its output held.
// Reset empties the queue and clears all valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generation_unit import sqvg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sqvg_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output sqvg_out_t out_data
);

	logic       f_valid, f_ready, b_valid, b_ready;
	sqvg_quad_t f_data, b_data;

	sqvg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_data   (f_data)
	);

	sqvg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_data),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	sqvg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_data    (b_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* sim/sprite_quad_vertex_generation_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite quad vertex generation unit testbench
// Sends sprite quads and checks each of the four vertices that come back
// against a predictor of the rotation, scaling and texture arithmetic.
// Both channels idle at random, apart from one test. The receiver also holds
// off once for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generation_unit_tb;
	import sqvg_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	sqvg_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	sqvg_out_t out_data;

	sqvg_out_t vertex_queue[$];
	int        errors;
	int        in_idle_pct;
	int        out_idle_pct;
	int        hold_cycles;

	sprite_quad_vertex_generation_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic longint quarter_sine(longint t);
		longint t2;
		longint inner;
		longint mid;
		t2 = (t * t) >>> 14;
		inner = longint'(SIN_B) - ((t2 * longint'(SIN_C)) >>> 14);
		mid = longint'(SIN_A) - ((t2 * inner) >>> 14);
		return (t * mid) >>> 14;
	endfunction

	function automatic longint angle_sine(logic [15:0] a);
		longint s;
		if (a[14]) begin
			s = quarter_sine(16384 - longint'(a[13:0]));
		end else begin
			s = quarter_sine(longint'(a[13:0]));
		end
		return a[15] ? -s : s;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// Arithmetic shift on a 64-bit signed value floors, as the rounding needs.
	task automatic predict_vertices(sqvg_in_t q);
		longint sx, sy, sw, sh, dx, dy, dw, dh, su, sv, cx, cy, sn, cs;
		longint ox, oy, xd, yd, ax, ay;
		sqvg_out_t v;
		sx = q.src_xy[15:0];
		sy = q.src_xy[31:16];
		sw = q.src_size[15:0];
		sh = q.src_size[31:16];
		dx = longint'($signed(q.dst_xy[15:0]));
		dy = longint'($signed(q.dst_xy[31:16]));
		dw = q.dst_size[15:0];
		dh = q.dst_size[31:16];
		su = q.tex_scale[15:0];
		sv = q.tex_scale[31:16];
		cx = (sw != 0) ? ((longint'(q.pivot[15:0]) << 12) / sw) : 0;
		cy = (sh != 0) ? ((longint'(q.pivot[31:16]) << 12) / sh) : 0;
		sn = angle_sine(q.angle);
		cs = angle_sine(q.angle + 16'd16384);
		for (int j = 0; j < 4; j++) begin
			ox = CORNER_OX[j];
			oy = CORNER_OY[j];
			xd = (ox * 65536 - cx) * dw;
			yd = (oy * 65536 - cy) * dh;
			ax = dx * (64'sd1 << 30) + xd * cs - yd * sn;
			ay = dy * (64'sd1 << 30) + xd * sn + yd * cs;
			v.pos_x = clamp32((ax + (64'sd1 << 17)) >>> 18);
			v.pos_y = clamp32((ay + (64'sd1 << 17)) >>> 18);
			v.tex_u = clamp32((sx + ox * sw) * su);
			v.tex_v = clamp32(65536 - (sy + oy * sh) * sv);
			v.tint_out = q.tint;
			v.corner = j[1:0];
			v.last = (j == 3);
			vertex_queue.push_back(v);
		end
	endtask

	// Valid drops only while the sender idles, so back-to-back transfers keep
	// it high without a second assignment in the same time step.
	task automatic send_quad(sqvg_in_t q);
		while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= q;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		predict_vertices(q);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (vertex_queue.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic sqvg_in_t random_quad();
		sqvg_in_t q;
		q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			16'($urandom), $urandom};
		// Mostly sizes small enough that results stay in range.
		if ($urandom_range(3) != 0) begin
			q.src_size = {16'($urandom_range(256)), 16'($urandom_range(256))};
			q.dst_size = {16'($urandom_range(4096)), 16'($urandom_range(4096))};
			q.pivot = {16'($urandom_range(4096)), 16'($urandom_range(4096))};
		end
		return q;
	endfunction

	// Output side: random ready, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	always @(posedge clk) begin
		sqvg_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (vertex_queue.size() == 0) begin
				$display("%0t: unexpected vertex %h", $time, out_data);
				errors++;
			end else begin
				e = vertex_queue.pop_front();
				if (out_data.pos_x !== e.pos_x)
					$display("%0t: pos_x exp %h got %h", $time, e.pos_x, out_data.pos_x);
				if (out_data.pos_y !== e.pos_y)
					$display("%0t: pos_y exp %h got %h", $time, e.pos_y, out_data.pos_y);
				if (out_data.tex_u !== e.tex_u)
					$display("%0t: tex_u exp %h got %h", $time, e.tex_u, out_data.tex_u);
				if (out_data.tex_v !== e.tex_v)
					$display("%0t: tex_v exp %h got %h", $time, e.tex_v, out_data.tex_v);
				if (out_data.tint_out !== e.tint_out)
					$display("%0t: tint exp %h got %h", $time, e.tint_out,
						out_data.tint_out);
				if (out_data.corner !== e.corner)
					$display("%0t: corner exp %0d got %0d", $time, e.corner,
						out_data.corner);
				if (out_data.last !== e.last)
					$display("%0t: last exp %b got %b", $time, e.last, out_data.last);
				if (out_data !== e)
					errors++;
			end
		end
	end

	task automatic test_directed();
		sqvg_in_t q;
		q = '0;
		send_quad(q);
		q = '1;
		send_quad(q);
		// Zero source width and height remove the centre term.
		q = {32'h0010_0020, 32'h0000_0000, 32'h0100_0200, 32'h0400_0400,
			32'h0080_0080, 32'h0100_0100, 16'h2000, 32'hdeadbeef};
		send_quad(q);
		// One angle per quadrant and on each quadrant boundary.
		for (int a = 0; a < 8; a++) begin
			q = {32'h0004_0008, 32'h0020_0010, 32'h8000_7fff, 32'h0200_0100,
				32'h0100_0080, 32'h0400_0800, 16'(a * 8192 + (a % 2) * 77),
				32'h1234_5678 + a};
			send_quad(q);
		end
		// Saturation of texture coordinates.
		q = {32'hffff_ffff, 32'h0001_0001, 32'h7fff_7fff, 32'hffff_ffff,
			32'h0000_0000, 32'hffff_ffff, 16'h0000, 32'h0};
		send_quad(q);
		q = {32'hffff_ffff, 32'hffff_ffff, 32'h8000_8000, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 16'h8000, 32'hffffffff};
		send_quad(q);
		q.angle = 16'h4000;
		q.pivot = 32'h0001_0001;
		send_quad(q);
		q.angle = 16'hc000;
		q.src_size = 32'h0003_0007;
		send_quad(q);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			send_quad(random_quad());
		end
	endtask

	task automatic test_backpressure();
		hold_cycles <= 200;
		test_random(12);
		wait_drained();
		// The sender pauses here until every vertex is back.
		test_random(8);
	endtask

	task automatic test_no_idle();
		in_idle_pct = 0;
		out_idle_pct = 0;
		test_random(60);
		in_idle_pct = 34;
		out_idle_pct = 34;
	endtask

	initial begin
		errors = 0;
		in_idle_pct = 34;
		out_idle_pct = 34;
		hold_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(100);
		test_backpressure();
		test_no_idle();
		test_random(120);
		wait_drained();
		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
